// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the fraction reducer.
// Depends on nothing; each macro takes a label, clock, active-low reset, expressions and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when the condition holds, the consequence holds too.
`define AST_IMPLY(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when the condition holds, the consequence holds in the next cycle.
`define AST_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/frgcd_pkg.sv =====
// Package for the fraction reducer: value width, payload structs and sequencer codes.
// Depends on nothing; used by fraction_reducer_gcd_unit and its testbench.
package frgcd_pkg;

  // Width of numerator and denominator values.
  localparam int WIDTH = 31;
  // Width of the divider bit counter, which counts WIDTH-1 down to 0.
  localparam int CNT_W = $clog2(WIDTH);

  // Input item.
  typedef struct packed {
    logic [WIDTH-1:0] numerator_in;
    logic [WIDTH-1:0] denominator_in;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [WIDTH-1:0] reduced_numerator;
    logic [WIDTH-1:0] reduced_denominator;
  } out_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  // What the current division is for.
  typedef enum logic [1:0] {
    OP_MOD_A = 2'd0,
    OP_MOD_B = 2'd1,
    OP_QUO_N = 2'd2,
    OP_QUO_D = 2'd3
  } op_t;

endpackage

// ===== rtl/fraction_reducer_gcd_unit.sv =====
// Per item: accept in idle, then alternate a check state and a Euclid remainder division
// until one operand is zero, then divide the numerator and the denominator by the GCD and
// present the result. Items are handled one at a time; the shared restoring divider retires
// one quotient bit per cycle and serves both the remainder and the quotient divisions.
// Reset: rst_n, synchronous, active low, returns the sequencer to idle; data is not reset.
// Depends on frgcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fraction_reducer_gcd_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  frgcd_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output frgcd_pkg::out_t  out_data
);

  localparam int W = frgcd_pkg::WIDTH;

  frgcd_pkg::state_t state_r, state_nxt;
  frgcd_pkg::op_t    op_r, op_nxt;

  // Operands of the Euclid loop and the original fraction.
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [W-1:0] n_r, n_nxt;
  logic [W-1:0] d_r, d_nxt;
  logic [W-1:0] g_r, g_nxt;

  // Shared divider registers.
  logic [W-1:0]                q_r, q_nxt;
  logic [W-1:0]                rem_r, rem_nxt;
  logic [W-1:0]                dv_r, dv_nxt;
  logic [frgcd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // Result registers.
  logic [W-1:0] res_num_r, res_num_nxt;
  logic [W-1:0] res_den_r, res_den_nxt;

  // One restoring division step: shift in the next dividend bit and try a subtract.
  logic [W:0]   trial;
  logic [W+1:0] diff;
  logic         ge;
  logic [W-1:0] rem_step;
  logic [W-1:0] q_step;

  assign trial    = {rem_r, q_r[W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dv_r};
  assign ge       = ~diff[W+1];
  assign rem_step = ge ? diff[W-1:0] : trial[W-1:0];
  assign q_step   = {q_r[W-2:0], ge};

  // Handshake outputs follow the sequencer state.
  assign in_ready  = (state_r == frgcd_pkg::ST_IDLE);
  assign out_valid = (state_r == frgcd_pkg::ST_OUT);
  assign out_data.reduced_numerator   = res_num_r;
  assign out_data.reduced_denominator = res_den_r;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    n_nxt       = n_r;
    d_nxt       = d_r;
    g_nxt       = g_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    dv_nxt      = dv_r;
    cnt_nxt     = cnt_r;
    res_num_nxt = res_num_r;
    res_den_nxt = res_den_r;

    case (state_r)
      frgcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_data.numerator_in;
          d_nxt     = in_data.denominator_in;
          a_nxt     = in_data.numerator_in;
          b_nxt     = in_data.denominator_in;
          state_nxt = frgcd_pkg::ST_CHECK;
        end
      end

      frgcd_pkg::ST_CHECK: begin
        rem_nxt = '0;
        cnt_nxt = frgcd_pkg::CNT_W'(W - 1);
        if ((a_r == '0) || (b_r == '0)) begin
          // One operand is zero, so the other one is the divisor.
          g_nxt = a_r | b_r;
          if ((a_r | b_r) == '0) begin
            res_num_nxt = '0;
            res_den_nxt = '0;
            state_nxt   = frgcd_pkg::ST_OUT;
          end else begin
            q_nxt     = n_r;
            dv_nxt    = a_r | b_r;
            op_nxt    = frgcd_pkg::OP_QUO_N;
            state_nxt = frgcd_pkg::ST_DIV;
          end
        end else if (a_r > b_r) begin
          q_nxt     = a_r;
          dv_nxt    = b_r;
          op_nxt    = frgcd_pkg::OP_MOD_A;
          state_nxt = frgcd_pkg::ST_DIV;
        end else begin
          q_nxt     = b_r;
          dv_nxt    = a_r;
          op_nxt    = frgcd_pkg::OP_MOD_B;
          state_nxt = frgcd_pkg::ST_DIV;
        end
      end

      frgcd_pkg::ST_DIV: begin
        q_nxt   = q_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          case (op_r)
            frgcd_pkg::OP_MOD_A: begin
              a_nxt     = rem_step;
              state_nxt = frgcd_pkg::ST_CHECK;
            end
            frgcd_pkg::OP_MOD_B: begin
              b_nxt     = rem_step;
              state_nxt = frgcd_pkg::ST_CHECK;
            end
            frgcd_pkg::OP_QUO_N: begin
              // Numerator done; start the denominator with the same divisor.
              res_num_nxt = q_step;
              q_nxt       = d_r;
              rem_nxt     = '0;
              dv_nxt      = g_r;
              cnt_nxt     = frgcd_pkg::CNT_W'(W - 1);
              op_nxt      = frgcd_pkg::OP_QUO_D;
            end
            frgcd_pkg::OP_QUO_D: begin
              res_den_nxt = q_step;
              state_nxt   = frgcd_pkg::ST_OUT;
            end
            default: begin
              state_nxt = frgcd_pkg::ST_IDLE;
            end
          endcase
        end
      end

      frgcd_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = frgcd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = frgcd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frgcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    g_r       <= g_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    dv_r      <= dv_nxt;
    cnt_r     <= cnt_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
  end

  // Checks on the sequencer and the shared divider.
  `AST_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
  `AST_IMPLY(a_div_nonzero, clk, rst_n, state_r == frgcd_pkg::ST_DIV, dv_r != '0, "divide by zero")
  `AST_NEXT(a_out_to_idle, clk, rst_n, out_valid && out_ready, in_ready, "no idle after transfer")
  `AST_NEXT(a_accept_check, clk, rst_n, in_valid && in_ready, state_r == frgcd_pkg::ST_CHECK, "no check after accept")

endmodule

// ===== verif/fraction_reducer_gcd_unit_tb.sv =====
// Self-checking testbench for fraction_reducer_gcd_unit: directed edge fractions, random
// traffic with bursts, gaps and result stalls, each result checked against a local GCD model.
// Depends on frgcd_pkg and the fraction_reducer_gcd_unit RTL.
`timescale 1ns / 1ps

module fraction_reducer_gcd_unit_tb;

  localparam int W = frgcd_pkg::WIDTH;
  localparam logic [W-1:0] MAX_VAL = '1;
  localparam int RANDOM_ITEMS = 912;
  // The slowest single items are neighbouring Fibonacci inputs.
  localparam int DRAIN_CYCLES = 1600;
  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int HOLD_OFF_CYCLES = 4000;

  typedef enum int {
    READY_ALWAYS  = 0,
    READY_RANDOM  = 1,
    READY_PATTERN = 2,
    READY_SPARSE  = 3
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  frgcd_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  frgcd_pkg::out_t out_data;

  frgcd_pkg::out_t pending_reductions[$];
  int mismatch_count = 0;
  longint cycle_count = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int hold_off_left = 0;

  fraction_reducer_gcd_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Lowest-terms form of a fraction, using Euclid's remainder loop.
  function automatic frgcd_pkg::out_t reduce_fraction(input frgcd_pkg::in_t item);
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] divisor;
    frgcd_pkg::out_t res;
    a = item.numerator_in;
    b = item.denominator_in;
    while (a != '0 && b != '0) begin
      if (a > b) begin
        a = a % b;
      end else begin
        b = b % a;
      end
    end
    // One of the two is zero here, so the sum is the divisor.
    divisor = a + b;
    if (divisor == '0) begin
      res = '0;
    end else begin
      res.reduced_numerator   = item.numerator_in / divisor;
      res.reduced_denominator = item.denominator_in / divisor;
    end
    return res;
  endfunction

  // Random fraction with a positive denominator, drawn from several shapes so that
  // shared factors, long Euclid chains and trivial ratios all show up often.
  function automatic void random_fraction(output logic [W-1:0] num,
                                          output logic [W-1:0] den);
    int unsigned pick;
    longint unsigned factor;
    longint unsigned scale;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned t;
    longint unsigned n64;
    longint unsigned d64;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n64 = 64'($urandom);
      d64 = 64'($urandom_range(1, MAX_VAL));
    end else if (pick < 55) begin
      factor = 64'($urandom_range(1, 65535));
      scale = 64'(MAX_VAL) / factor;
      n64 = factor * 64'($urandom_range(0, 32'(scale)));
      d64 = factor * 64'($urandom_range(1, 32'(scale)));
    end else if (pick < 80) begin
      n64 = 64'($urandom_range(0, 255));
      d64 = 64'($urandom_range(1, 255));
    end else if (pick < 92) begin
      // Neighboring Fibonacci numbers give the longest remainder chains.
      lo = 64'd1;
      hi = 64'd1;
      repeat ($urandom_range(10, 44)) begin
        t = lo + hi;
        lo = hi;
        hi = t;
      end
      factor = 64'($urandom_range(1, 32'(64'(MAX_VAL) / hi)));
      if ($urandom_range(0, 1) == 1) begin
        n64 = lo * factor;
        d64 = hi * factor;
      end else begin
        n64 = hi * factor;
        d64 = lo * factor;
      end
    end else begin
      d64 = 64'($urandom_range(1, MAX_VAL));
      case ($urandom_range(0, 2))
        0: begin
          n64 = 64'd0;
        end
        1: begin
          n64 = d64;
        end
        default: begin
          n64 = d64 * 64'($urandom_range(1, 32'(64'(MAX_VAL) / d64)));
        end
      endcase
    end
    num = n64[W-1:0];
    den = d64[W-1:0];
  endfunction

  // Offers one fraction and records its reduction once the transfer happens.
  // Valid stays high afterwards; the caller sends again or idles at the next falling edge.
  task automatic send_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
    frgcd_pkg::in_t item;
    item.numerator_in = num;
    item.denominator_in = den;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_reductions = {pending_reductions, reduce_fraction(item)};
  endtask

  // Drops valid for a number of cycles, with noise on the idle payload.
  task automatic idle_input(input int unsigned cycles);
    logic [63:0] raw;
    frgcd_pkg::in_t noise;
    if (cycles != 0) begin
      raw = {$urandom, $urandom};
      noise = raw[$bits(frgcd_pkg::in_t)-1:0];
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= noise;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every recorded reduction has come back.
  task automatic wait_for_results();
    idle_input(1);
    while (pending_reductions.size() != 0) @(posedge clk);
  endtask

  // Field extremes, worst-case Euclid chains and the zero special cases.
  task automatic test_directed_edges();
    ready_mode = READY_ALWAYS;
    send_fraction(31'd0, 31'd1);
    send_fraction(31'd0, MAX_VAL);
    send_fraction(MAX_VAL, MAX_VAL);
    send_fraction(MAX_VAL, 31'd1);
    send_fraction(31'd1, MAX_VAL);
    send_fraction(31'd1, 31'd1);
    send_fraction(31'd6, 31'd4);
    send_fraction(31'd4, 31'd6);
    send_fraction(31'd1836311903, 31'd1134903170);
    send_fraction(31'd1134903170, 31'd1836311903);
    send_fraction(31'h4000_0000, 31'h2000_0000);
    send_fraction(31'd2147483646, 31'd1073741823);
    send_fraction(31'd2147483646, 31'd3);
    send_fraction(31'h2AAA_AAAA, 31'h5555_5555);
    send_fraction(31'h5555_5555, 31'h2AAA_AAAA);
    send_fraction(31'd12345, 31'd12345);
    send_fraction(MAX_VAL, 31'd2147483629);
    idle_input(3);
    // Zero denominator: a nonzero numerator gives 1/0, and zero over zero gives 0/0.
    send_fraction(31'd5, 31'd0);
    send_fraction(MAX_VAL, 31'd0);
    send_fraction(31'd0, 31'd0);
    send_fraction(31'd1000000000, 31'd750000000);
    wait_for_results();
  endtask

  // Bulk random traffic, one receiver pattern per phase; the first phase has no idling.
  task automatic test_random_traffic();
    logic [W-1:0] num;
    logic [W-1:0] den;
    int unsigned burst_left;
    for (int phase = 0; phase < 4; phase++) begin
      ready_mode = ready_mode_t'(phase);
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        random_fraction(num, den);
        send_fraction(num, den);
        burst_left--;
        if (burst_left == 0) begin
          if (phase != 0) begin
            idle_input($urandom_range(0, 15));
          end
          burst_left = $urandom_range(1, 12);
        end
      end
      wait_for_results();
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_result_backpressure();
    logic [W-1:0] num;
    logic [W-1:0] den;
    ready_mode = READY_ALWAYS;
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (8) begin
      random_fraction(num, den);
      send_fraction(num, den);
    end
    wait_for_results();
  endtask

  // The sender goes quiet until everything is back, then resumes at once.
  task automatic test_pause_and_resume();
    logic [W-1:0] num;
    logic [W-1:0] den;
    ready_mode = READY_RANDOM;
    repeat (3) begin
      repeat ($urandom_range(1, 6)) begin
        random_fraction(num, den);
        send_fraction(num, den);
      end
      wait_for_results();
    end
  endtask

  // Receiver: a long hold-off when one is requested, otherwise the current pattern.
  initial begin : result_receiver
    int pattern_step;
    pattern_step = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        case (ready_mode)
          READY_ALWAYS: begin
            out_ready <= 1'b1;
          end
          READY_RANDOM: begin
            out_ready <= ($urandom_range(0, 1) == 1);
          end
          READY_PATTERN: begin
            out_ready <= (pattern_step < 3);
            pattern_step = (pattern_step == 6) ? 0 : pattern_step + 1;
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Each result transfer is compared with the oldest outstanding reduction.
  always @(posedge clk) begin : check_results
    frgcd_pkg::out_t expected;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_reductions.size() == 0) begin
        $error("unexpected result transfer: %0d/%0d",
               out_data.reduced_numerator, out_data.reduced_denominator);
        mismatch_count++;
      end else begin
        expected = pending_reductions.pop_front();
        if (out_data.reduced_numerator !== expected.reduced_numerator) begin
          $error("reduced_numerator: expected %0d, got %0d",
                 expected.reduced_numerator, out_data.reduced_numerator);
          mismatch_count++;
        end
        if (out_data.reduced_denominator !== expected.reduced_denominator) begin
          $error("reduced_denominator: expected %0d, got %0d",
                 expected.reduced_denominator, out_data.reduced_denominator);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : run_watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : test_sequence
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_result_backpressure();
    test_random_traffic();
    test_pause_and_resume();
    ready_mode = READY_ALWAYS;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
